[rtl/spiral_matrix_fill_top_macros.svh]
// assertion macros for the spiral matrix fill block
`ifndef SPIRAL_MATRIX_FILL_TOP_MACROS_SVH
`define SPIRAL_MATRIX_FILL_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define SMF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/smf_pkg.sv]
// shared constants and types for the spiral matrix fill block
package smf_pkg;

  localparam int MAX_SIZE_DEF = 16;
  localparam int SIZE_W       = 5;
  localparam int DIR_W        = 2;
  localparam int VALUE_W      = 9;
  localparam int COORD_W      = 4;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 16;

  localparam logic REG_SIZE = 1'b0;
  localparam logic REG_DIR  = 1'b1;

  localparam logic [DIR_W-1:0] DIR_CW  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_CCW = 2'd1;

  localparam logic KIND_GEN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic start;
    logic fill;
    logic ccw;
  } walk_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } walk_stat_t;

endpackage

[rtl/smf_ram.sv]
// generic single-write, single-read ram with registered read data
module smf_ram #(
  parameter int WIDTH  = 9,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/smf_walk.sv]
// clear sweep and spiral walk sequencer driving the grid write port
module smf_walk import smf_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF,
  parameter int DEPTH    = MAX_SIZE * MAX_SIZE,
  parameter int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int IDX_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1,
  parameter int NW       = $clog2(MAX_SIZE + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  walk_ctrl_t         ctrl,
  input  logic [NW-1:0]      n,
  output walk_stat_t         stat,
  output logic               we,
  output logic [ADDR_W-1:0]  waddr,
  output logic [VALUE_W-1:0] wdata
);

  localparam int KW = $clog2(DEPTH + 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CLR  = 2'd1;
  localparam logic [1:0] PH_WALK = 2'd2;

  logic [1:0]        phase;
  logic [ADDR_W-1:0] clr_cnt;
  logic              fill;
  logic              ccw;
  logic [KW-1:0]     total;
  logic [KW-1:0]     k;
  logic [IDX_W-1:0]  row, col, top, bottom, left, right;
  logic [1:0]        d;

  logic [IDX_W-1:0]  row_next, col_next, top_next, bottom_next, left_next, right_next;
  logic [1:0]        d_next;
  logic              clr_last;
  logic              walk_last;

  assign clr_last  = (clr_cnt == ADDR_W'(DEPTH - 1));
  assign walk_last = (k == total);

  always_comb begin
    row_next    = row;
    col_next    = col;
    top_next    = top;
    bottom_next = bottom;
    left_next   = left;
    right_next  = right;
    d_next      = d;
    unique case ({ccw, d})
      3'b000: begin
        if (col == right) begin
          top_next = top + 1'b1;
          d_next   = 2'd1;
          row_next = row + 1'b1;
        end else begin
          col_next = col + 1'b1;
        end
      end
      3'b001: begin
        if (row == bottom) begin
          right_next = right - 1'b1;
          d_next     = 2'd2;
          col_next   = col - 1'b1;
        end else begin
          row_next = row + 1'b1;
        end
      end
      3'b010: begin
        if (col == left) begin
          bottom_next = bottom - 1'b1;
          d_next      = 2'd3;
          row_next    = row - 1'b1;
        end else begin
          col_next = col - 1'b1;
        end
      end
      3'b011: begin
        if (row == top) begin
          left_next = left + 1'b1;
          d_next    = 2'd0;
          col_next  = col + 1'b1;
        end else begin
          row_next = row - 1'b1;
        end
      end
      3'b100: begin
        if (row == bottom) begin
          left_next = left + 1'b1;
          d_next    = 2'd1;
          col_next  = col + 1'b1;
        end else begin
          row_next = row + 1'b1;
        end
      end
      3'b101: begin
        if (col == right) begin
          bottom_next = bottom - 1'b1;
          d_next      = 2'd2;
          row_next    = row - 1'b1;
        end else begin
          col_next = col + 1'b1;
        end
      end
      3'b110: begin
        if (row == top) begin
          right_next = right - 1'b1;
          d_next     = 2'd3;
          col_next   = col - 1'b1;
        end else begin
          row_next = row - 1'b1;
        end
      end
      3'b111: begin
        if (col == left) begin
          top_next = top + 1'b1;
          d_next   = 2'd0;
          row_next = row + 1'b1;
        end else begin
          col_next = col - 1'b1;
        end
      end
      default: begin
        d_next = d;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_CLR;
      clr_cnt <= '0;
      fill    <= 1'b0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (ctrl.start) begin
            phase   <= PH_CLR;
            clr_cnt <= '0;
            fill    <= ctrl.fill;
          end
        end
        PH_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_last) begin
            phase <= fill ? PH_WALK : PH_IDLE;
          end
        end
        PH_WALK: begin
          if (walk_last) begin
            phase <= PH_IDLE;
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase == PH_IDLE && ctrl.start) begin
      ccw    <= ctrl.ccw;
      total  <= KW'(KW'(n) * KW'(n));
      row    <= '0;
      col    <= '0;
      top    <= '0;
      left   <= '0;
      bottom <= IDX_W'(n - 1'b1);
      right  <= IDX_W'(n - 1'b1);
      d      <= 2'd0;
      k      <= KW'(1);
    end else if (phase == PH_WALK) begin
      row    <= row_next;
      col    <= col_next;
      top    <= top_next;
      bottom <= bottom_next;
      left   <= left_next;
      right  <= right_next;
      d      <= d_next;
      k      <= k + 1'b1;
    end
  end

  always_comb begin
    we    = (phase == PH_CLR) || (phase == PH_WALK);
    waddr = clr_cnt;
    wdata = '0;
    if (phase == PH_WALK) begin
      waddr = ADDR_W'(32'(row) * MAX_SIZE + 32'(col));
      wdata = VALUE_W'(k);
    end
  end

  assign stat.busy = (phase != PH_IDLE);
  assign stat.done = (phase == PH_CLR && clr_last && !fill) || (phase == PH_WALK && walk_last);

endmodule

[rtl/spiral_matrix_fill_top.sv]
// top level of the spiral matrix fill block: stream ports, config registers, grid store
// read item: grid read at accept, result registered in ST_OUT; one item at a time
// generate item: clear sweep of the grid, then n*n walk writes, then the result output
// no walk when the direction does not fill or n is zero
// reset: clearing pass over all MAX_SIZE*MAX_SIZE cells, s_tready low until it ends
// reset values: size 4, direction 0, grid all zero
`include "spiral_matrix_fill_top_macros.svh"

module spiral_matrix_fill_top import smf_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // row[3:0], col[7:4]
  input  logic                  s_tuser,   // kind[0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // value[8:0], in_range[9], zero[15:10]
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW     = $clog2(MAX_SIZE + 1);

  localparam logic [2:0] ST_BOOT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_GEN  = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;

  logic [2:0]         state;
  logic [SIZE_W-1:0]  size;
  logic [DIR_W-1:0]   dir;
  logic               rd_hit;

  logic [NW-1:0]        n_eff;
  logic [COORD_W-1:0]   in_row, in_col;
  logic                 in_range;
  logic                 accept;
  logic                 out_free;
  logic                 cfg_wr;
  walk_ctrl_t           wctrl;
  walk_stat_t           wstat;
  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  logic [VALUE_W-1:0]   wdata;
  logic                 re;
  logic [ADDR_W-1:0]    raddr;
  logic [VALUE_W-1:0]   rdata;

  assign n_eff    = (32'(size) > MAX_SIZE) ? NW'(MAX_SIZE) : NW'(size);
  assign in_row   = s_tdata[3:0];
  assign in_col   = s_tdata[7:4];
  assign in_range = (32'(in_row) < 32'(n_eff)) && (32'(in_col) < 32'(n_eff));
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign re    = accept && (s_tuser == KIND_READ) && in_range;
  assign raddr = ADDR_W'(32'(in_row) * MAX_SIZE + 32'(in_col));

  assign wctrl.start = accept && (s_tuser == KIND_GEN);
  assign wctrl.fill  = ((dir == DIR_CW) || (dir == DIR_CCW)) && (n_eff != '0);
  assign wctrl.ccw   = (dir == DIR_CCW);

  smf_walk #(
    .MAX_SIZE (MAX_SIZE)
  ) u_walk (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (wctrl),
    .n     (n_eff),
    .stat  (wstat),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata)
  );

  smf_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_BOOT;
      m_tvalid <= 1'b0;
      rd_hit   <= 1'b0;
    end else begin
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_BOOT: begin
          if (wstat.done) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            rd_hit <= (s_tuser == KIND_READ) && in_range;
            state  <= (s_tuser == KIND_GEN) ? ST_GEN : ST_OUT;
          end
        end
        ST_GEN: begin
          if (wstat.done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tdata <= {(OUT_DATA_W - VALUE_W - 1)'(0), rd_hit, rd_hit ? rdata : VALUE_W'(0)};
    end
  end

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= SIZE_W'(4);
      dir  <= DIR_CW;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SIZE) begin
        size <= pwdata[SIZE_W-1:0];
      end else begin
        dir <= pwdata[DIR_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_SIZE) begin
      prdata = {(CFG_DATA_W - SIZE_W)'(0), size};
    end else begin
      prdata = {(CFG_DATA_W - DIR_W)'(0), dir};
    end
  end

  `SMF_ASSERT_NOW(a_ready_walk_idle, s_tready, !wstat.busy, "input ready while walk busy")
  `SMF_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "item accepted back to back")
  `SMF_ASSERT_NEXT(a_out_loads, state == ST_OUT && out_free, m_tvalid, "result not presented")
  `SMF_ASSERT_NOW(a_zero_when_out, m_tvalid && !m_tdata[9], m_tdata[8:0] == '0, "value without range")

endmodule

[tb/sv/tb_spiral_matrix_fill_top.sv]
// testbench for spiral_matrix_fill_top: directed table and random items against a predictor
`timescale 1ns / 100ps

module tb_spiral_matrix_fill_top import smf_pkg::*; ();

  localparam int GRID_CELLS = MAX_SIZE_DEF * MAX_SIZE_DEF;
  localparam int IDLE_LIMIT = 20000;
  localparam int CFG_SETTLE = 4;
  localparam int END_SETTLE = 600;
  localparam int SEGMENTS = 10;
  localparam int SEG_ITEMS = 140;

  localparam logic [DIR_W-1:0] DIR_NONE = 2'd2;
  localparam logic [DIR_W-1:0] DIR_NONE_ALT = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_SIZE = {REG_SIZE, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_DIR = {REG_DIR, 2'b00};

  typedef enum logic [1:0] {
    SR_GEN,
    SR_READ,
    SR_SIZE,
    SR_DIR
  } stim_op_e;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               in_range;
  } cell_result_t;

  typedef struct {
    stim_op_e           op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    int                 arg;
    bit                 typed;
    cell_result_t       exp;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // row[3:0], col[7:4]
  logic                  s_tuser;   // kind[0]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // value[8:0], in_range[9]
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic [SIZE_W-1:0]  cfg_size;
  logic [DIR_W-1:0]   cfg_dir;
  logic [VALUE_W-1:0] grid_m [GRID_CELLS];
  cell_result_t       pending_q [$];
  stim_row_t          dir_table [$];
  int                 err_cnt;
  int                 idle_cnt;
  int                 send_idle_pct;
  int                 recv_idle_pct;

  spiral_matrix_fill_top u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  function automatic int eff_side();
    return (cfg_size > MAX_SIZE_DEF) ? MAX_SIZE_DEF : int'(cfg_size);
  endfunction

  function automatic int row_step(logic ccw, int d);
    case (d)
      0: return ccw ? 1 : 0;
      1: return ccw ? 0 : 1;
      2: return ccw ? -1 : 0;
      default: return ccw ? 0 : -1;
    endcase
  endfunction

  function automatic int col_step(logic ccw, int d);
    case (d)
      0: return ccw ? 0 : 1;
      1: return ccw ? 1 : 0;
      2: return ccw ? 0 : -1;
      default: return ccw ? -1 : 0;
    endcase
  endfunction

  function automatic void spiral_fill();
    int n, r, c, d, nr, nc, total, k, t;
    logic ccw;
    n = eff_side();
    foreach (grid_m[i]) grid_m[i] = '0;
    if (cfg_dir != DIR_CW && cfg_dir != DIR_CCW) return;
    if (n == 0) return;
    ccw = (cfg_dir == DIR_CCW);
    r = 0;
    c = 0;
    d = 0;
    total = n * n;
    for (k = 1; k <= total; k++) begin
      grid_m[r * MAX_SIZE_DEF + c] = VALUE_W'(k);
      if (k == total) break;
      for (t = 0; t < 4; t++) begin
        nr = r + row_step(ccw, d);
        nc = c + col_step(ccw, d);
        if (nr >= 0 && nc >= 0 && nr < n && nc < n && grid_m[nr * MAX_SIZE_DEF + nc] == '0)
          break;
        d = (d + 1) % 4;
      end
      r += row_step(ccw, d);
      c += col_step(ccw, d);
      if (r < 0 || c < 0 || r >= n || c >= n) break;
    end
  endfunction

  function automatic cell_result_t predict_cell(logic kind, logic [COORD_W-1:0] row,
                                                logic [COORD_W-1:0] col);
    cell_result_t res;
    int n;
    res = '0;
    n = eff_side();
    if (kind == KIND_GEN) begin
      spiral_fill();
    end else if (row < n && col < n) begin
      res.value = grid_m[row * MAX_SIZE_DEF + col];
      res.in_range = 1'b1;
    end
    return res;
  endfunction

  function automatic stim_row_t mk_row(stim_op_e op, int row, int col, int arg, int typed,
                                       int exp_value, int exp_in_range);
    stim_row_t sr;
    sr.op = op;
    sr.row = COORD_W'(row);
    sr.col = COORD_W'(col);
    sr.arg = arg;
    sr.typed = (typed != 0);
    sr.exp.value = VALUE_W'(exp_value);
    sr.exp.in_range = (exp_in_range != 0);
    return sr;
  endfunction

  task automatic wait_drained(int settle);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    wait_drained(CFG_SETTLE);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_SIZE) cfg_size = data[SIZE_W-1:0];
    else if (addr == ADDR_DIR) cfg_dir = data[DIR_W-1:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_item(logic kind, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                           bit typed, cell_result_t typed_exp);
    cell_result_t res;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = kind;
    s_tdata = {col, row};
    do @(posedge clk); while (!s_tready);
    res = predict_cell(kind, row, col);
    pending_q.push_back(typed ? typed_exp : res);
  endtask

  // result checker
  always @(posedge clk) begin
    cell_result_t exp;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected item, value %0d in_range %0d", $time,
                 m_tdata[VALUE_W-1:0], m_tdata[VALUE_W]);
        err_cnt++;
      end else begin
        exp = pending_q.pop_front();
        if (m_tdata[VALUE_W-1:0] !== exp.value) begin
          $display("%0t: value expected %0d actual %0d", $time, exp.value,
                   m_tdata[VALUE_W-1:0]);
          err_cnt++;
        end
        if (m_tdata[VALUE_W] !== exp.in_range) begin
          $display("%0t: in_range expected %0d actual %0d", $time, exp.in_range,
                   m_tdata[VALUE_W]);
          err_cnt++;
        end
      end
    end
  end

  always @(negedge clk) begin
    m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int seg, i, n, sz, dr;
    logic [COORD_W-1:0] row, col;
    cell_result_t none;
    stim_row_t sr;

    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    err_cnt = 0;
    idle_cnt = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    none = '0;
    cfg_size = SIZE_W'(4);
    cfg_dir = DIR_CW;
    foreach (grid_m[j]) grid_m[j] = '0;

    // directed table
    dir_table.push_back(mk_row(SR_READ, 0, 0, 0, 1, 0, 1));
    dir_table.push_back(mk_row(SR_READ, 15, 15, 0, 1, 0, 0));
    dir_table.push_back(mk_row(SR_GEN, 7, 9, 0, 1, 0, 0));
    dir_table.push_back(mk_row(SR_READ, 0, 0, 0, 1, 1, 1));
    dir_table.push_back(mk_row(SR_READ, 1, 0, 0, 0, 0, 0));
    dir_table.push_back(mk_row(SR_READ, 3, 3, 0, 0, 0, 0));
    dir_table.push_back(mk_row(SR_READ, 0, 4, 0, 1, 0, 0));
    dir_table.push_back(mk_row(SR_READ, 4, 0, 0, 1, 0, 0));
    dir_table.push_back(mk_row(SR_DIR, 0, 0, int'(DIR_CCW), 0, 0, 0));
    dir_table.push_back(mk_row(SR_GEN, 0, 0, 0, 1, 0, 0));
    dir_table.push_back(mk_row(SR_READ, 0, 1, 0, 0, 0, 0));
    dir_table.push_back(mk_row(SR_READ, 1, 0, 0, 0, 0, 0));
    dir_table.push_back(mk_row(SR_DIR, 0, 0, int'(DIR_NONE), 0, 0, 0));
    dir_table.push_back(mk_row(SR_GEN, 0, 0, 0, 1, 0, 0));
    dir_table.push_back(mk_row(SR_READ, 0, 0, 0, 1, 0, 1));
    dir_table.push_back(mk_row(SR_DIR, 0, 0, int'(DIR_NONE_ALT), 0, 0, 0));
    dir_table.push_back(mk_row(SR_GEN, 15, 15, 0, 1, 0, 0));
    dir_table.push_back(mk_row(SR_READ, 2, 1, 0, 1, 0, 1));
    dir_table.push_back(mk_row(SR_DIR, 0, 0, int'(DIR_CW), 0, 0, 0));
    dir_table.push_back(mk_row(SR_SIZE, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(mk_row(SR_GEN, 0, 0, 0, 1, 0, 0));
    dir_table.push_back(mk_row(SR_READ, 0, 0, 0, 1, 0, 0));
    dir_table.push_back(mk_row(SR_SIZE, 0, 0, 16, 0, 0, 0));
    dir_table.push_back(mk_row(SR_GEN, 0, 0, 0, 1, 0, 0));
    dir_table.push_back(mk_row(SR_READ, 15, 15, 0, 0, 0, 0));
    dir_table.push_back(mk_row(SR_READ, 15, 0, 0, 0, 0, 0));
    dir_table.push_back(mk_row(SR_SIZE, 0, 0, 31, 0, 0, 0));
    dir_table.push_back(mk_row(SR_DIR, 0, 0, int'(DIR_CCW), 0, 0, 0));
    dir_table.push_back(mk_row(SR_GEN, 0, 0, 0, 1, 0, 0));
    dir_table.push_back(mk_row(SR_READ, 15, 15, 0, 0, 0, 0));
    dir_table.push_back(mk_row(SR_READ, 0, 15, 0, 0, 0, 0));
    // size shrinks without a new spiral: store kept, range follows the new size
    dir_table.push_back(mk_row(SR_SIZE, 0, 0, 1, 0, 0, 0));
    dir_table.push_back(mk_row(SR_READ, 0, 0, 0, 1, 1, 1));
    dir_table.push_back(mk_row(SR_READ, 0, 1, 0, 1, 0, 0));
    dir_table.push_back(mk_row(SR_GEN, 0, 0, 0, 1, 0, 0));
    dir_table.push_back(mk_row(SR_READ, 0, 0, 0, 1, 1, 1));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_table[j]) begin
      sr = dir_table[j];
      case (sr.op)
        SR_SIZE: write_reg(ADDR_SIZE, CFG_DATA_W'(sr.arg));
        SR_DIR:  write_reg(ADDR_DIR, CFG_DATA_W'(sr.arg));
        SR_GEN:  send_item(KIND_GEN, sr.row, sr.col, sr.typed, sr.exp);
        default: send_item(KIND_READ, sr.row, sr.col, sr.typed, sr.exp);
      endcase
    end

    // random segments, each with its own setting and idling mode
    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin sz = 1;  dr = int'(DIR_CW);       end
        1: begin sz = 16; dr = int'(DIR_CCW);      end
        2: begin sz = 0;  dr = int'(DIR_CCW);      end
        3: begin sz = 31; dr = int'(DIR_CW);       end
        4: begin sz = 5;  dr = int'(DIR_NONE);     end
        5: begin sz = 3;  dr = int'(DIR_NONE_ALT); end
        6: begin sz = 16; dr = int'(DIR_CW);       end
        7: begin sz = 2;  dr = int'(DIR_CCW);      end
        default: begin
          sz = $urandom_range(0, 31);
          dr = $urandom_range(0, 3);
        end
      endcase
      write_reg(ADDR_SIZE, CFG_DATA_W'(sz));
      write_reg(ADDR_DIR, CFG_DATA_W'(dr));
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 60; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 60; end
        default: begin send_idle_pct = 9; recv_idle_pct = 9; end
      endcase
      for (i = 0; i < SEG_ITEMS; i++) begin
        row = COORD_W'($urandom_range(0, 15));
        col = COORD_W'($urandom_range(0, 15));
        if ((i == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 19) == 0) begin
          send_item(KIND_GEN, row, col, 1'b0, none);
        end else begin
          n = eff_side();
          if (n > 0 && $urandom_range(0, 3) != 0) begin
            row = COORD_W'($urandom_range(0, n - 1));
            col = COORD_W'($urandom_range(0, n - 1));
          end
          send_item(KIND_READ, row, col, 1'b0, none);
        end
        if ($urandom_range(0, 199) == 0) wait_drained(0);
      end
    end

    wait_drained(END_SETTLE);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/smf_pkg.sv
rtl/smf_ram.sv
rtl/smf_walk.sv
rtl/spiral_matrix_fill_top.sv
tb/sv/tb_spiral_matrix_fill_top.sv
